@@ sv/etcf_pkg.sv @@
`timescale 1ns / 1ps
// etcf_pkg: shared types, codes and sizes of the edge timestamp capture fifo
// no dependencies; imported by every module of the block

package etcf_pkg;

	localparam int RING_DEPTH  = 1024;
	localparam int MAX_DRAIN   = 64;
	localparam int IDX_W       = $clog2(RING_DEPTH);
	localparam int PTR_W       = $clog2(2 * RING_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QP_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = 3;

	localparam logic [15:0] PPS_INTERVAL_RST = 16'd1000;
	localparam logic [6:0]  MAX_DRAIN_C      = 7'(MAX_DRAIN);
	localparam logic        REG_PPS_INTERVAL = 1'b0;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_EDGE  = 2'd1,
		OP_DRAIN = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_STARTED     = 3'd0,
		ST_STOPPED     = 3'd1,
		ST_STORED      = 3'd2,
		ST_OVERFLOW    = 3'd3,
		ST_IGNORED     = 3'd4,
		ST_DRAINED     = 3'd5,
		ST_DRAIN_EMPTY = 3'd6
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_DRAIN
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] stamp;
		logic [39:0] rt_sec;
		logic [29:0] rt_nsec;
		logic [6:0]  drain_max;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        last_of_run;
		logic [63:0] entry_stamp;
		logic [63:0] entry_seq;
		logic        entry_pps;
		logic [39:0] entry_sec;
		logic [29:0] entry_nsec;
		logic [63:0] edges_seen;
		logic [63:0] seconds_seen;
		logic [63:0] overflow_count;
		logic [10:0] fill_level;
	} res_t;

	typedef struct packed {
		logic [63:0] stamp;
		logic [63:0] seq;
		logic        pps;
		logic [39:0] sec;
		logic [29:0] nsec;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] stamp;
		logic [39:0] rt_sec;
		logic [29:0] rt_nsec;
		logic [6:0]  limit;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

@@ sv/edge_timestamp_capture_fifo_core.sv @@
`timescale 1ns / 1ps
// edge_timestamp_capture_fifo_core: top level, config register and the
// front/back split; uses etcf_pkg, etcf_front, etcf_back
//
//   channel   handshake                        payload
//   -------   ------------------------------   -----------------------
//   input     start && !busy                   item   (etcf_pkg::item_t)
//   result    result_strobe, one cycle each    result (etcf_pkg::res_t)
//   config    psel & penable & pwrite, pready  paddr / pwdata / prdata
//
// start, stop and edge commands: result via the queue and result register,
// one command per cycle while no drain is running, set by the back end
// drain of n entries: one result per cycle from the ring's
// registered read port, then the back end takes the next command
// the two-entry command queue raises busy when full; the receiver cannot
// stall, results are never held
// reset clears control state only; the ring needs no clearing pass since
// only entries written since start are ever read

module edge_timestamp_capture_fifo_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  etcf_pkg::item_t             item,
	// result side
	output logic                        result_strobe,
	output etcf_pkg::res_t              result,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [etcf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import etcf_pkg::*;

	logic [15:0] interval_q;
	logic        reg_sel;
	logic        reg_wr;
	cmd_req_t    head;
	logic        pop;

	// single register, word index taken from the upper address bit
	assign reg_sel = (paddr[ADDR_W-1] == REG_PPS_INTERVAL);
	assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {16'd0, interval_q} : 32'd0;

	// second-check interval; takes effect at next reload or start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= PPS_INTERVAL_RST;
		end else if (reg_wr) begin
			interval_q <= pwdata[15:0];
		end
	end

	// front: transfer, decode, clamp drain count, queue
	etcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.head   (head),
		.pop    (pop)
	);

	// back: counters, ring memory, result stream
	etcf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.interval      (interval_q),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

@@ sv/etcf_front.sv @@
`timescale 1ns / 1ps
// etcf_front: accepts items, decodes the op and clamps the drain count,
// and holds them in a short command queue; uses etcf_pkg

module etcf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  etcf_pkg::item_t    item,
	output etcf_pkg::cmd_req_t head,
	input  logic               pop
);
	import etcf_pkg::*;

	cmd_t             q_mem [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_q;
	logic [QP_W-1:0]  rd_q;
	logic [QC_W-1:0]  cnt_q;
	cmd_t             cls;
	logic             push;
	logic             pull;

	function automatic logic [QP_W-1:0] qp_inc(input logic [QP_W-1:0] p);
		logic [QP_W-1:0] r;
		r = (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + QP_W'(1);
		return r;
	endfunction

	always_comb begin
		cls.op      = op_t'(item.op);
		cls.stamp   = item.stamp;
		cls.rt_sec  = item.rt_sec;
		cls.rt_nsec = item.rt_nsec;
		cls.limit   = (item.drain_max > MAX_DRAIN_C) ? MAX_DRAIN_C : item.drain_max;
	end

	assign busy       = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign pull       = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = q_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= qp_inc(wr_q);
			if (pull) rd_q <= qp_inc(rd_q);
			case ({push, pull})
				2'b10:   cnt_q <= cnt_q + QC_W'(1);
				2'b01:   cnt_q <= cnt_q - QC_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= cls;
	end

endmodule

@@ sv/etcf_back.sv @@
`timescale 1ns / 1ps
// etcf_back: executes queued commands, owns the capture counters and the
// entry ring memory, streams drained entries; uses etcf_pkg

module etcf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  etcf_pkg::cmd_req_t head,
	output logic               pop,
	input  logic [15:0]        interval,
	output logic               result_strobe,
	output etcf_pkg::res_t     result
);
	import etcf_pkg::*;

	entry_t           ring_mem [RING_DEPTH];
	entry_t           rd_data_q;

	state_t           state_q, state_n;
	logic             cap_q, cap_n;
	logic [PTR_W-1:0] wp_q, wp_n, rp_q, rp_n;
	logic [63:0]      ec_q, ec_n, sc_q, sc_n, dc_q, dc_n;
	logic [15:0]      cd_q, cd_n, cd_dec;
	logic [39:0]      prev_q, prev_n;
	logic [6:0]       rem_q, rem_n;
	res_t             res_q, res_n;
	logic             res_vld_q, res_vld_n;
	logic             rd_pend_q, rd_pend_n;
	logic             rd_last_q, rd_last_n;
	logic [PTR_W-1:0] rd_fill_q, rd_fill_n;
	logic [PTR_W-1:0] fill;
	status_t          status_n;
	logic             mark;
	logic             wr_en, rd_en;
	entry_t           wr_ent;

	// pointers count modulo twice the depth, a power of two, so the
	// difference wraps on its own
	function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] w,
	                                             input logic [PTR_W-1:0] r);
		logic [PTR_W-1:0] f;
		f = w - r;
		return f;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(2 * RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p >= PTR_W'(RING_DEPTH)) ? p - PTR_W'(RING_DEPTH) : p;
		return r[IDX_W-1:0];
	endfunction

	assign fill   = fill_of(wp_q, rp_q);
	assign cd_dec = cd_q - 16'd1;

	always_comb begin
		state_n   = state_q;
		cap_n     = cap_q;
		wp_n      = wp_q;
		rp_n      = rp_q;
		ec_n      = ec_q;
		sc_n      = sc_q;
		dc_n      = dc_q;
		cd_n      = cd_q;
		prev_n    = prev_q;
		rem_n     = rem_q;
		res_vld_n = 1'b0;
		rd_pend_n = 1'b0;
		rd_last_n = rd_last_q;
		rd_fill_n = rd_fill_q;
		status_n  = ST_IGNORED;
		mark      = 1'b0;
		pop       = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_ent    = '0;
		case (state_q)
			BK_IDLE: begin
				if (head.valid && !rd_pend_q) begin
					pop       = 1'b1;
					res_vld_n = 1'b1;
					case (head.cmd.op)
						OP_START: begin
							wp_n     = '0;
							rp_n     = '0;
							ec_n     = '0;
							sc_n     = '0;
							dc_n     = '0;
							cd_n     = interval;
							prev_n   = head.cmd.rt_sec;
							cap_n    = 1'b1;
							status_n = ST_STARTED;
						end
						OP_STOP: begin
							cap_n    = 1'b0;
							status_n = ST_STOPPED;
						end
						OP_EDGE: begin
							if (!cap_q) begin
								status_n = ST_IGNORED;
							end else begin
								cd_n = cd_dec;
								if (cd_dec == 16'd0) begin
									cd_n = interval;
									if (head.cmd.rt_sec != prev_q) begin
										mark   = 1'b1;
										prev_n = head.cmd.rt_sec;
										sc_n   = sc_q + 64'd1;
									end
								end
								if (fill >= PTR_W'(RING_DEPTH)) begin
									dc_n     = dc_q + 64'd1;
									status_n = ST_OVERFLOW;
								end else begin
									wr_en       = 1'b1;
									wr_ent.stamp = head.cmd.stamp;
									wr_ent.seq  = ec_q;
									wr_ent.pps  = mark;
									wr_ent.sec  = mark ? head.cmd.rt_sec : 40'd0;
									wr_ent.nsec = mark ? head.cmd.rt_nsec : 30'd0;
									wp_n        = ptr_inc(wp_q);
									status_n    = ST_STORED;
								end
								ec_n = ec_q + 64'd1;
							end
						end
						OP_DRAIN: begin
							if (head.cmd.limit == 7'd0 || fill == '0) begin
								status_n = ST_DRAIN_EMPTY;
							end else begin
								res_vld_n = 1'b0;
								rem_n     = head.cmd.limit;
								state_n   = BK_DRAIN;
							end
						end
						default: status_n = ST_IGNORED;
					endcase
				end
			end
			BK_DRAIN: begin
				// one pop per cycle, data comes back registered next cycle
				rd_en     = 1'b1;
				rp_n      = ptr_inc(rp_q);
				rem_n     = rem_q - 7'd1;
				rd_pend_n = 1'b1;
				rd_fill_n = fill - PTR_W'(1);
				rd_last_n = (rem_q == 7'd1) || (fill == PTR_W'(1));
				if (rd_last_n) state_n = BK_IDLE;
			end
			default: state_n = BK_IDLE;
		endcase

		res_n                = res_q;
		if (res_vld_n) begin
			res_n.status         = status_n;
			res_n.last_of_run    = 1'b1;
			res_n.entry_stamp    = '0;
			res_n.entry_seq      = '0;
			res_n.entry_pps      = 1'b0;
			res_n.entry_sec      = '0;
			res_n.entry_nsec     = '0;
			res_n.edges_seen     = ec_n;
			res_n.seconds_seen   = sc_n;
			res_n.overflow_count = dc_n;
			res_n.fill_level     = 11'(fill_of(wp_n, rp_n));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cap_q     <= 1'b0;
			wp_q      <= '0;
			rp_q      <= '0;
			ec_q      <= '0;
			sc_q      <= '0;
			dc_q      <= '0;
			cd_q      <= PPS_INTERVAL_RST;
			prev_q    <= '0;
			rem_q     <= '0;
			res_vld_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			cap_q     <= cap_n;
			wp_q      <= wp_n;
			rp_q      <= rp_n;
			ec_q      <= ec_n;
			sc_q      <= sc_n;
			dc_q      <= dc_n;
			cd_q      <= cd_n;
			prev_q    <= prev_n;
			rem_q     <= rem_n;
			res_vld_q <= res_vld_n;
			rd_pend_q <= rd_pend_n;
		end
	end

	always_ff @(posedge clk) begin
		res_q     <= res_n;
		rd_last_q <= rd_last_n;
		rd_fill_q <= rd_fill_n;
	end

	always_ff @(posedge clk) begin
		if (wr_en) ring_mem[ptr_idx(wp_q)] <= wr_ent;
		if (rd_en) rd_data_q <= ring_mem[ptr_idx(rp_q)];
	end

	always_comb begin
		result = res_q;
		if (rd_pend_q) begin
			result.status         = ST_DRAINED;
			result.last_of_run    = rd_last_q;
			result.entry_stamp    = rd_data_q.stamp;
			result.entry_seq      = rd_data_q.seq;
			result.entry_pps      = rd_data_q.pps;
			result.entry_sec      = rd_data_q.sec;
			result.entry_nsec     = rd_data_q.nsec;
			result.edges_seen     = ec_q;
			result.seconds_seen   = sc_q;
			result.overflow_count = dc_q;
			result.fill_level     = 11'(rd_fill_q);
		end
	end

	assign result_strobe = rd_pend_q | res_vld_q;

endmodule

@@ sv/etcf_checker.sv @@
`timescale 1ns / 1ps
// etcf_checker: port-level checks on the result stream, bound to the top
// level; uses etcf_pkg

module etcf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           result_strobe,
	input etcf_pkg::res_t result
);
	import etcf_pkg::*;

	// a drain streams one entry per cycle and the ring shrinks by one each
	a_drain_stream: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_DRAINED && !result.last_of_run
		|=> result_strobe && result.status == ST_DRAINED
		&& result.fill_level == $past(result.fill_level) - 11'd1)
		else $error("drain stream broke or fill level off");

	// only drained entries carry entry fields, others end their run
	a_non_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status != ST_DRAINED
		|-> result.last_of_run && result.entry_stamp == '0 && result.entry_seq == '0
		&& !result.entry_pps && result.entry_sec == '0 && result.entry_nsec == '0)
		else $error("non-drain result with entry data or not last");

	// start clears counters and ring
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status == ST_STARTED
		|-> result.edges_seen == '0 && result.seconds_seen == '0
		&& result.overflow_count == '0 && result.fill_level == '0)
		else $error("start left state behind");

	// ring never reports more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> result.fill_level <= 11'(RING_DEPTH))
		else $error("fill level above ring depth");

endmodule

bind edge_timestamp_capture_fifo_core etcf_checker u_etcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.result_strobe (result_strobe),
	.result        (result)
);

@@ verif/edge_timestamp_capture_fifo_core_tb.sv @@
`timescale 1ns / 1ps
// edge_timestamp_capture_fifo_core_tb: self-checking bench for the edge capture fifo,
// tracks ring and counters per command and checks every result strobe field by field
// depends on etcf_pkg and edge_timestamp_capture_fifo_core

module edge_timestamp_capture_fifo_core_tb;

	import etcf_pkg::*;

	// byte address of the interval register on the register port
	localparam logic [ADDR_W-1:0] PPS_INTERVAL_ADDR = ADDR_W'(4 * REG_PPS_INTERVAL);

	// tracks what the capture unit holds and the results it owes
	class capture_tracker;
		logic [15:0]      interval;
		bit               capturing;
		logic [PTR_W-1:0] wr_ptr;
		logic [PTR_W-1:0] rd_ptr;
		logic [63:0]      edge_cnt;
		logic [63:0]      mark_cnt;
		logic [63:0]      drop_cnt;
		logic [15:0]      countdown;
		logic [39:0]      prev_sec;
		entry_t           ring [RING_DEPTH];
		res_t             due_results [$];
		int               errors;

		function new();
			interval  = PPS_INTERVAL_RST;
			countdown = PPS_INTERVAL_RST;
			capturing = 1'b0;
			wr_ptr    = '0;
			rd_ptr    = '0;
			edge_cnt  = '0;
			mark_cnt  = '0;
			drop_cnt  = '0;
			prev_sec  = '0;
			errors    = 0;
		endfunction

		function logic [PTR_W-1:0] held();
			return wr_ptr - rd_ptr;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		function res_t snapshot(status_t st, logic last);
			res_t r;
			r                = '0;
			r.status         = st;
			r.last_of_run    = last;
			r.edges_seen     = edge_cnt;
			r.seconds_seen   = mark_cnt;
			r.overflow_count = drop_cnt;
			r.fill_level     = held();
			return r;
		endfunction

		// works out the results of one accepted command
		function void log_command(item_t it);
			op_t     op;
			bit      mark;
			status_t st;
			entry_t  slot;
			res_t    r;
			int      limit;
			int      n;
			op = op_t'(it.op);
			case (op)
				OP_START: begin
					wr_ptr    = '0;
					rd_ptr    = '0;
					edge_cnt  = '0;
					mark_cnt  = '0;
					drop_cnt  = '0;
					countdown = interval;
					prev_sec  = it.rt_sec;
					capturing = 1'b1;
					due_results.push_back(snapshot(ST_STARTED, 1'b1));
				end
				OP_STOP: begin
					capturing = 1'b0;
					due_results.push_back(snapshot(ST_STOPPED, 1'b1));
				end
				OP_EDGE: begin
					if (!capturing) begin
						due_results.push_back(snapshot(ST_IGNORED, 1'b1));
					end else begin
						mark = 1'b0;
						// a zero interval wraps the 16-bit countdown, so the check comes only after a full turn of it
						countdown = countdown - 16'd1;
						if (countdown == 16'd0) begin
							countdown = interval;
							if (it.rt_sec != prev_sec) begin
								mark     = 1'b1;
								prev_sec = it.rt_sec;
								mark_cnt = mark_cnt + 64'd1;
							end
						end
						if (held() >= RING_DEPTH) begin
							drop_cnt = drop_cnt + 64'd1;
							st       = ST_OVERFLOW;
						end else begin
							slot.stamp = it.stamp;
							slot.seq   = edge_cnt;
							slot.pps   = mark;
							slot.sec   = mark ? it.rt_sec : '0;
							slot.nsec  = mark ? it.rt_nsec : '0;
							ring[wr_ptr[IDX_W-1:0]] = slot;
							wr_ptr = wr_ptr + PTR_W'(1);
							st     = ST_STORED;
						end
						edge_cnt = edge_cnt + 64'd1;
						due_results.push_back(snapshot(st, 1'b1));
					end
				end
				default: begin
					// drain: pops up to the clamped count, allowed in any capture state
					limit = (it.drain_max > MAX_DRAIN) ? MAX_DRAIN : int'(it.drain_max);
					n     = (int'(held()) < limit) ? int'(held()) : limit;
					if (n == 0)
						due_results.push_back(snapshot(ST_DRAIN_EMPTY, 1'b1));
					for (int i = 0; i < n; i++) begin
						slot          = ring[rd_ptr[IDX_W-1:0]];
						rd_ptr        = rd_ptr + PTR_W'(1);
						r             = snapshot(ST_DRAINED, i == n - 1);
						r.entry_stamp = slot.stamp;
						r.entry_seq   = slot.seq;
						r.entry_pps   = slot.pps;
						r.entry_sec   = slot.sec;
						r.entry_nsec  = slot.nsec;
						due_results.push_back(r);
					end
				end
			endcase
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				$error("result with no command waiting: status %0d", got.status);
				errors++;
				return;
			end
			want = due_results.pop_front();
			cmp("status", 64'(want.status), 64'(got.status));
			cmp("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
			cmp("entry_stamp", want.entry_stamp, got.entry_stamp);
			cmp("entry_seq", want.entry_seq, got.entry_seq);
			cmp("entry_pps", 64'(want.entry_pps), 64'(got.entry_pps));
			cmp("entry_sec", 64'(want.entry_sec), 64'(got.entry_sec));
			cmp("entry_nsec", 64'(want.entry_nsec), 64'(got.entry_nsec));
			cmp("edges_seen", want.edges_seen, got.edges_seen);
			cmp("seconds_seen", want.seconds_seen, got.seconds_seen);
			cmp("overflow_count", want.overflow_count, got.overflow_count);
			cmp("fill_level", 64'(want.fill_level), 64'(got.fill_level));
		endfunction
	endclass

	// clock, reset and block ports; the ones the bench drives are known from time zero
	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic        busy;
	item_t       item    = '0;
	logic        result_strobe;
	res_t        result;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr  = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	capture_tracker sb = new();

	// chance in percent that the idle stretch after a transfer goes on
	int idle_pct = 0;

	// wall clock and free-running counter behind the random edges
	logic [39:0] wall_sec  = 40'd100;
	logic [63:0] stamp_ctr = 64'd0;

	// interval and sender idling per random phase; covers zero and both extremes
	logic [15:0] phase_interval [7] = '{16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd1000, 16'd1, 16'd7};
	int          phase_idle     [7] = '{0, 68, 14, 68, 0, 68, 14};

	edge_timestamp_capture_fifo_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// every strobed result is a transfer the receiver must take
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1)
			sb.check_result(result);
	end

	function automatic item_t mk(op_t op, logic [63:0] stamp, logic [39:0] sec,
		logic [29:0] nsec, logic [6:0] cnt);
		item_t it;
		it.op        = op;
		it.stamp     = stamp;
		it.rt_sec    = sec;
		it.rt_nsec   = nsec;
		it.drain_max = cnt;
		return it;
	endfunction

	// unused fields of every command carry random bits too
	function automatic item_t cmd_item(op_t op, logic [6:0] cnt);
		return mk(op, {$urandom, $urandom}, 40'({$urandom, $urandom}),
			30'($urandom_range(999999999)), cnt);
	endfunction

	// edges follow a running clock: the second often moves on, now and then it jumps
	function automatic item_t edge_item();
		int pick;
		item_t it;
		pick = $urandom_range(99);
		if (pick < 35)
			wall_sec = wall_sec + 40'd1;
		else if (pick < 38)
			wall_sec = 40'({$urandom, $urandom});
		stamp_ctr = stamp_ctr + 64'($urandom_range(1, 100000));
		it        = cmd_item(OP_EDGE, 7'($urandom));
		it.rt_sec = wall_sec;
		if ($urandom_range(99) >= 3)
			it.stamp = stamp_ctr;
		return it;
	endfunction

	// mostly short drains, with empty, full-size and over-limit counts mixed in
	function automatic logic [6:0] drain_count();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 7'd0;
		if (pick < 20)
			return 7'($urandom_range(MAX_DRAIN + 1, 127));
		if (pick < 35)
			return MAX_DRAIN_C;
		return 7'($urandom_range(1, 16));
	endfunction

	// one command transfer, then a random idle stretch
	task automatic send_item(input item_t it);
		int gap;
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		sb.log_command(it);
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until the block owes nothing more
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PPS_INTERVAL_ADDR;
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.interval = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_read_check();
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PPS_INTERVAL_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.cmp("check_interval", 64'(sb.interval), 64'(got[15:0]));
	endtask

	// well-formed capture runs with random content, plus some stray commands
	task automatic run_traffic(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 75) begin
				if (!sb.capturing || $urandom_range(3) == 0) begin
					send_item(cmd_item(OP_START, 7'($urandom)));
					sent++;
				end
				repeat ($urandom_range(1, 10)) begin
					send_item(edge_item());
					sent++;
				end
				send_item(cmd_item(OP_DRAIN, drain_count()));
				sent++;
				if ($urandom_range(3) == 0) begin
					send_item(cmd_item(OP_STOP, 7'($urandom)));
					sent++;
				end
			end else begin
				send_item(cmd_item(op_t'($urandom_range(3)), 7'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// interval comes out of reset at its default, then every edge is checked
		reg_read_check();
		reg_write(16'd1);
		reg_read_check();

		// directed: idle commands, field extremes, marks, drain limits, restart
		send_item(mk(OP_STOP, '0, '0, '0, 7'd0));
		send_item(mk(OP_EDGE, '1, '1, 30'd999999999, 7'h7F));
		send_item(mk(OP_DRAIN, '0, '0, '0, 7'd5));
		send_item(mk(OP_START, '0, '0, '0, 7'd0));
		send_item(mk(OP_EDGE, '0, '0, '0, 7'd0));
		send_item(mk(OP_EDGE, '1, '1, 30'd999999999, 7'h7F));
		send_item(mk(OP_EDGE, 64'h8000_0000_0000_0001, '1, 30'd1, 7'd1));
		send_item(mk(OP_EDGE, 64'h5555_AAAA_5555_AAAA, 40'd1, 30'h2000_0000, 7'd2));
		send_item(mk(OP_DRAIN, '0, '0, '0, 7'd0));
		send_item(mk(OP_DRAIN, '1, '1, '0, 7'd2));
		send_item(mk(OP_DRAIN, '0, '0, '0, 7'h7F));
		send_item(mk(OP_DRAIN, '0, '0, '0, MAX_DRAIN_C));
		// restart while capturing at the top of the seconds range
		send_item(mk(OP_START, '1, '1, 30'd999999999, 7'h7F));
		send_item(mk(OP_EDGE, 64'd10, 40'd7, 30'd500, 7'd0));
		send_item(mk(OP_EDGE, 64'd20, 40'd7, 30'd600, 7'd0));
		send_item(mk(OP_EDGE, 64'd30, '1, 30'd700, 7'd0));
		send_item(mk(OP_STOP, '1, '1, '0, 7'h7F));
		send_item(mk(OP_EDGE, 64'd40, 40'd8, 30'd800, 7'd0));
		// the ring keeps its entries after a stop
		send_item(mk(OP_DRAIN, '0, '0, '0, 7'd1));
		send_item(mk(OP_DRAIN, '0, '0, '0, MAX_DRAIN_C));
		send_item(mk(OP_STOP, '0, '0, '0, 7'd0));

		// random phases; each pause also lets every owed result arrive first
		for (int p = 0; p < 7; p++) begin
			wait_idle();
			reg_write(phase_interval[p]);
			reg_read_check();
			idle_pct = phase_idle[p];
			run_traffic(24);
		end

		// let the last results drain out, then wait quietly for strays
		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog far above the slowest correct run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
